// ----- rtl/core/goldbach_partition_counter_assert.svh -----
// Assertion macros for the Goldbach partition counter.
// Each check is sampled on the rising edge of clk_i and is off while rst_ni is low.
`ifndef GOLDBACH_PARTITION_COUNTER_ASSERT_SVH
`define GOLDBACH_PARTITION_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS
`define GPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define GPC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define GPC_ASSERT(lbl, prop)
`define GPC_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- rtl/core/gpc_pkg.sv -----
`default_nettype none

package gpc_pkg;

  // Largest number covered by the composite map.
  localparam int unsigned MaxN     = 65536;
  localparam int unsigned MapDepth = MaxN + 1;
  localparam int unsigned AddrW    = $clog2(MapDepth);

  // Fixed field widths of the query and result words.
  localparam int unsigned TargetW = 17;
  localparam int unsigned CountW  = 16;

  typedef logic [AddrW-1:0] addr_t;

  // One cycle's request to the composite map.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    logic  wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } ram_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/gpc_ram.sv -----
`default_nettype none

module gpc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ----- rtl/core/gpc_sieve.sv -----
`default_nettype none

module gpc_sieve (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      rdata_i,
  output gpc_pkg::ram_req_t req_o,
  output logic           done_o
);

  localparam int unsigned SumW = gpc_pkg::AddrW + 1;

  typedef enum logic [5:0] {
    SvClear = 6'b000001,
    SvRead  = 6'b000010,
    SvWait  = 6'b000100,
    SvMark  = 6'b001000,
    SvNext  = 6'b010000,
    SvDone  = 6'b100000
  } sv_state_e;

  sv_state_e           state_q, state_d;
  logic [SumW-1:0]     addr_q, addr_d;
  logic [SumW-1:0]     sq_q, sq_d;
  gpc_pkg::addr_t      i_q, i_d;
  logic [SumW-1:0]     add_a, add_b, add_sum;

  // The adder shared by the clearing pass, the marking walk and the square update.
  assign add_sum = add_a + add_b;

  // Sequencer: clear the map (0 and 1 written as composite), then mark multiples.
  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    sq_d          = sq_q;
    i_d           = i_q;
    add_a         = addr_q;
    add_b         = SumW'(1);
    req_o         = '0;
    req_o.raddr_a = i_q;
    unique case (state_q)
      SvClear: begin
        req_o.we    = 1'b1;
        req_o.waddr = addr_q[gpc_pkg::AddrW-1:0];
        req_o.wdata = (addr_q < SumW'(2));
        if (addr_q == SumW'(gpc_pkg::MaxN)) begin
          i_d     = gpc_pkg::AddrW'(2);
          sq_d    = SumW'(4);
          state_d = SvRead;
        end else begin
          addr_d = add_sum;
        end
      end
      SvRead: begin
        if (sq_q > SumW'(gpc_pkg::MaxN)) begin
          state_d = SvDone;
        end else begin
          state_d = SvWait;
        end
      end
      SvWait: begin
        if (!rdata_i) begin
          addr_d  = sq_q;
          state_d = SvMark;
        end else begin
          state_d = SvNext;
        end
      end
      SvMark: begin
        req_o.we    = 1'b1;
        req_o.waddr = addr_q[gpc_pkg::AddrW-1:0];
        req_o.wdata = 1'b1;
        add_b       = {1'b0, i_q};
        addr_d      = add_sum;
        if (add_sum > SumW'(gpc_pkg::MaxN)) begin
          state_d = SvNext;
        end
      end
      SvNext: begin
        // (i+1)^2 = i^2 + 2i + 1
        add_a   = sq_q;
        add_b   = {i_q, 1'b1};
        sq_d    = add_sum;
        i_d     = i_q + 1'b1;
        state_d = SvRead;
      end
      SvDone: begin
      end
      default: begin
        state_d = SvClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SvClear;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
    i_q  <= i_d;
  end

  assign done_o = (state_q == SvDone);

endmodule

`default_nettype wire

// ----- rtl/core/gpc_count.sv -----
`default_nettype none

module gpc_count (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         map_ready_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [gpc_pkg::TargetW-1:0]  target_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [gpc_pkg::CountW-1:0]   partition_count_o,
  input  wire logic                         rdata_a_i,
  input  wire logic                         rdata_b_i,
  output gpc_pkg::ram_req_t                 req_o
);

  typedef enum logic [2:0] {
    CtIdle   = 3'b001,
    CtRun    = 3'b010,
    CtFinish = 3'b100
  } ct_state_e;

  ct_state_e                    state_q, state_d;
  gpc_pkg::addr_t               n_q, n_d;
  gpc_pkg::addr_t               p_q, p_d;
  gpc_pkg::addr_t               q_q, q_d;
  gpc_pkg::addr_t               step;
  logic                         pend_q, pend_d;
  logic [gpc_pkg::CountW-1:0]   count_q, count_d;
  logic                         out_valid_q, out_valid_d;
  logic [gpc_pkg::CountW-1:0]   out_count_q, out_count_d;
  logic                         accept;
  logic                         in_range;
  logic                         hit;
  logic                         out_load;

  assign in_ready_o = map_ready_i && (state_q == CtIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = (32'(target_i) <= 32'(gpc_pkg::MaxN));
  assign out_load   = (state_q == CtFinish) && (!out_valid_q || out_ready_i);

  // Both bits read last cycle are prime: one more partition.
  assign hit  = pend_q && !rdata_a_i && !rdata_b_i;
  assign step = (p_q == gpc_pkg::AddrW'(2)) ? gpc_pkg::AddrW'(1) : gpc_pkg::AddrW'(2);

  // Walk p = 2, then every odd p from 3, while 2p <= n, reading p and n - p each cycle.
  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    p_d           = p_q;
    q_d           = q_q;
    pend_d        = 1'b0;
    count_d       = count_q;
    req_o         = '0;
    req_o.raddr_a = p_q;
    req_o.raddr_b = q_q;
    if (hit && (count_q != '1)) begin
      count_d = count_q + 1'b1;
    end
    unique case (state_q)
      CtIdle: begin
        if (accept) begin
          count_d = '0;
          n_d     = gpc_pkg::AddrW'(target_i);
          p_d     = gpc_pkg::AddrW'(2);
          q_d     = gpc_pkg::AddrW'(target_i) - gpc_pkg::AddrW'(2);
          state_d = in_range ? CtRun : CtFinish;
        end
      end
      CtRun: begin
        if ({p_q, 1'b0} <= {1'b0, n_q}) begin
          pend_d = 1'b1;
          p_d    = p_q + step;
          q_d    = q_q - step;
        end else begin
          state_d = CtFinish;
        end
      end
      CtFinish: begin
        if (out_load) begin
          state_d = CtIdle;
        end
      end
      default: begin
        state_d = CtIdle;
      end
    endcase
  end

  // Output register: holds the finished word until it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_count_d = count_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CtIdle;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    p_q         <= p_d;
    q_q         <= q_d;
    count_q     <= count_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o       = out_valid_q;
  assign partition_count_o = out_count_q;

endmodule

`default_nettype wire

// ----- rtl/core/goldbach_partition_counter.sv -----
// Per word: a word with target n is walked one p (2, then odd p up to n/2) per cycle.
// Words: one at a time; a new word is taken only after the last count is loaded into the output register.
// Reset: a clearing pass over all MAX_N + 1 entries, then the sieve marks multiples of each
// prime up to sqrt(MAX_N); no word is taken until then.
`default_nettype none

`include "goldbach_partition_counter_assert.svh"

module goldbach_partition_counter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [gpc_pkg::TargetW-1:0] target_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [gpc_pkg::CountW-1:0]  partition_count_o
);

  gpc_pkg::ram_req_t sv_req;
  gpc_pkg::ram_req_t ct_req;
  gpc_pkg::ram_req_t ram_req;
  logic              sieve_done;
  logic              rdata_a;
  logic              rdata_b;

  // Sieve builds the map after reset.
  gpc_sieve u_sieve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rdata_i(rdata_a),
    .req_o  (sv_req),
    .done_o (sieve_done)
  );

  // Query walker owns the map once the sieve is done.
  gpc_count u_count (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .map_ready_i      (sieve_done),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .target_i         (target_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .partition_count_o(partition_count_o),
    .rdata_a_i        (rdata_a),
    .rdata_b_i        (rdata_b),
    .req_o            (ct_req)
  );

  assign ram_req = sieve_done ? ct_req : sv_req;

  // Composite map, one bit per number 0..MAX_N.
  gpc_ram #(
    .Width(1),
    .Depth(gpc_pkg::MapDepth)
  ) u_map (
    .clk_i    (clk_i),
    .we_i     (ram_req.we),
    .waddr_i  (ram_req.waddr),
    .wdata_i  (ram_req.wdata),
    .raddr_a_i(ram_req.raddr_a),
    .raddr_b_i(ram_req.raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // No query is taken before the map is complete.
  `GPC_ASSERT(a_ready_after_sieve, in_ready_o |-> sieve_done)
  // The map is read-only while queries are served.
  `GPC_ASSERT_NEVER(a_no_write_after_sieve, sieve_done && ram_req.we)
  // Once complete, the map stays complete.
  `GPC_ASSERT(a_sieve_done_sticky, sieve_done |=> sieve_done)
  // A taken word keeps the block busy in the following cycle.
  `GPC_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)

endmodule

`default_nettype wire

// ----- tb/goldbach_partition_counter_tb.sv -----
`timescale 1ns / 1ps

module goldbach_partition_counter_tb;

  import gpc_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned NumRandom     = 76;
  // Worst case: reset clearing and sieve, then every word at full latency with
  // the longest gaps on both sides, the hold-off and the tail, taken three times.
  localparam longint unsigned LimitCycles =
    3 * (4 * MaxN + (NumRandom + 30) * (MaxN / 4 + 20) + HoldOffCycles + MaxN / 4);

  // One query word waiting to be offered, with the idle cycles before it.
  typedef struct {
    logic [TargetW-1:0] target;
    int unsigned        gap;
    bit                 drain;
  } query_t;

  // One partition count still owed by the block.
  typedef struct {
    logic [TargetW-1:0] target;
    logic [CountW-1:0]  count;
  } awaited_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [TargetW-1:0] target = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CountW-1:0]  partition_count;
  logic               hold_off = 1'b0;

  query_t      query_q[$];
  awaited_t    awaited_q[$];
  bit          not_prime [0:MaxN];
  int unsigned gap_count = 0;
  int unsigned stall_left = 0;
  int unsigned words_taken = 0;
  int unsigned results_seen = 0;
  int unsigned large_words = 0;
  int unsigned beyond_words = 0;
  int unsigned error_count = 0;

  goldbach_partition_counter DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .target_i          (target),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .partition_count_o (partition_count)
  );

  // Clock and a single reset at the start.
  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sieve of Eratosthenes over 0..MaxN; 0 and 1 are not prime.
  function automatic void build_sieve();
    for (int unsigned k = 0; k <= MaxN; k++) begin
      not_prime[k] = 1'b0;
    end
    not_prime[0] = 1'b1;
    not_prime[1] = 1'b1;
    for (int unsigned i = 2; i * i <= MaxN; i++) begin
      if (!not_prime[i]) begin
        for (int unsigned j = i * i; j <= MaxN; j += i) begin
          not_prime[j] = 1'b1;
        end
      end
    end
  endfunction

  // Number of prime pairs p <= q with p + q == n; zero beyond the map.
  function automatic logic [CountW-1:0] count_prime_pairs(logic [TargetW-1:0] n);
    int unsigned pairs;
    pairs = 0;
    if (n <= MaxN) begin
      for (int unsigned p = 2; 2 * p <= n; p++) begin
        if (!not_prime[p] && !not_prime[n - p] && pairs < 16'hFFFF) begin
          pairs++;
        end
      end
    end
    return pairs[CountW-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic add_query(logic [TargetW-1:0] n, int unsigned gap, bit drain);
    query_t q;
    q.target = n;
    q.gap    = gap;
    q.drain  = drain;
    query_q.insert(query_q.size(), q);
  endtask

  // Sender: offers queued words, records the expected count for each taken word.
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    logic   nxt_valid;
    query_t head;
    awaited_t owed;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      target    <= '0;
      gap_count <= 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        owed.target = target;
        owed.count  = count_prime_pairs(target);
        awaited_q.insert(awaited_q.size(), owed);
        words_taken++;
        if (target > MaxN) beyond_words++;
        else if (target > 4096) large_words++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && query_q.size() != 0) begin
        head = query_q[0];
        if (gap_count < head.gap) begin
          gap_count <= gap_count + 1;
        end else if (!head.drain || awaited_q.size() == 0) begin
          void'(query_q.pop_front());
          target    <= head.target;
          nxt_valid = 1'b1;
          gap_count <= 0;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Receiver: checks each count against the oldest expectation, stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin : collect_counts
    awaited_t want;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("count %0d arrived with no query outstanding",
                                    partition_count));
        end else begin
          want = awaited_q.pop_front();
          if (partition_count !== want.count) begin
            report_mismatch($sformatf("target %0d: count %0d, expected %0d",
                                      want.target, partition_count, want.count));
          end
        end
        // Results 51 to 70 get no random stall; the hold-off still applies.
        stall_left = (results_seen >= 50 && results_seen < 70) ? 0 : $urandom_range(0, 7);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ready <= !hold_off && stall_left == 0;
    end
  end

  // Long receiver hold-off while the sender keeps offering short words.
  initial begin
    while (words_taken < 55) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Stimulus: directed corners, then random queries, then the final check.
  initial begin
    logic [TargetW-1:0] n;
    int unsigned        pick;
    int unsigned        gap;
    build_sieve();

    // Targets below four, small odd and even numbers, and the ends of the map.
    for (int unsigned k = 0; k <= 12; k++) begin
      add_query(k[TargetW-1:0], $urandom_range(0, 7), 1'b0);
    end
    add_query(17'd27, 0, 1'b0);
    add_query(17'd100, 0, 1'b0);
    add_query(17'd1000, $urandom_range(0, 7), 1'b0);
    add_query(17'd21845, $urandom_range(0, 7), 1'b0);
    add_query(17'd43690, 0, 1'b0);
    add_query(TargetW'(MaxN), $urandom_range(0, 7), 1'b0);
    add_query(TargetW'(MaxN - 1), 0, 1'b0);
    add_query(TargetW'(MaxN - 2), $urandom_range(0, 7), 1'b0);
    // Targets beyond the map give a count of zero.
    add_query(TargetW'(MaxN + 1), 0, 1'b0);
    add_query(17'h1FFFF, $urandom_range(0, 7), 1'b0);
    add_query(17'h15555, 0, 1'b0);

    // Random part: mostly small targets, a few over the whole map and beyond it.
    for (int unsigned i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(0, 99);
      if (i >= 25 && i < 50) begin
        n   = TargetW'($urandom_range(0, 600));
        gap = 0;
      end else begin
        if (pick < 7) n = TargetW'($urandom_range(0, MaxN));
        else if (pick < 13) n = TargetW'($urandom_range(MaxN + 1, 17'h1FFFF));
        else n = TargetW'($urandom_range(0, 2047));
        gap = $urandom_range(0, 7);
      end
      // The sender waits for every count before random words 0 and 70.
      add_query(n, gap, i == 0 || i == 70);
    end

    while (query_q.size() != 0 || in_valid) @(posedge clk_i);
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (MaxN / 4 + 8) @(posedge clk_i);
    if (awaited_q.size() != 0) begin
      report_mismatch($sformatf("%0d counts never arrived", awaited_q.size()));
    end

    $display("Checked %0d counts for %0d words: %0d large targets, %0d beyond the map.",
             results_seen, words_taken, large_words, beyond_words);
    $display("Run included a %0d-cycle receiver hold-off and two full drains.",
             HoldOffCycles);
    if (error_count == 0) begin
      $display("goldbach_partition_counter: match");
    end else begin
      $display("goldbach_partition_counter: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("Timed out with %0d counts outstanding.", awaited_q.size());
    $display("goldbach_partition_counter: mismatch");
    $finish;
  end

endmodule
